/* hw/rtl/ptpd_pkg.sv */
// shared types and constants for the point transform with perspective divide
// no dependencies
package ptpd_pkg;

  localparam int NUM_CFG_REGS = 8;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_HALF_W   = 32;
  localparam int LANE_W       = 32;
  localparam int QUEUE_DEPTH  = 4;

  typedef struct packed {
    logic                  valid;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

endpackage

/* hw/rtl/ptpd_front.sv */
// front end: matrix registers, row vector by matrix products and sums, zero w detect
// depends on ptpd_pkg
module ptpd_front #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int TW          = 50
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptpd_pkg::cfg_write_t  cfg_wr,
  input  logic                  in_accept,
  input  logic [3*ptpd_pkg::LANE_W-1:0] in_data,
  output logic                  out_valid,
  output logic [4*TW-1:0]       out_t,
  output logic                  out_wz
);
  import ptpd_pkg::*;

  localparam int W = COORD_WIDTH;

  logic [CFG_DATA_W-1:0]  cfg_r [NUM_CFG_REGS];
  logic signed [W-1:0]    pt    [3];
  logic signed [W-1:0]    ent   [4][4];
  logic signed [2*W-1:0]  prod_r [3][4];
  logic signed [2*W-1:0]  prod_nxt [3][4];
  logic signed [TW-1:0]   t_r   [4];
  logic signed [TW-1:0]   t_nxt [4];
  logic                   v1_r, v2_r, wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG_REGS; i++) cfg_r[i] <= '0;
    end else if (cfg_wr.valid && (cfg_wr.addr < CFG_ADDR_W'(NUM_CFG_REGS))) begin
      cfg_r[cfg_wr.addr[$clog2(NUM_CFG_REGS)-1:0]] <= cfg_wr.data;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) pt[r] = in_data[r*LANE_W +: W];
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ent[r][c] = cfg_r[r*2 + c/2][(c%2)*CFG_HALF_W +: W];
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_nxt[r][c] = (2*W)'(pt[r]) * (2*W)'(ent[r][c]);
      end
    end
    // arithmetic shift gives the floor of each scaled product
    for (int c = 0; c < 4; c++) begin
      t_nxt[c] = TW'(prod_r[0][c] >>> FRAC_BITS) + TW'(prod_r[1][c] >>> FRAC_BITS)
               + TW'(prod_r[2][c] >>> FRAC_BITS) + TW'(ent[3][c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    t_r    <= t_nxt;
    wz_r   <= (t_nxt[3] == '0);
  end

  assign out_valid = v2_r;
  assign out_wz    = wz_r;
  assign out_t     = {t_r[3], t_r[2], t_r[1], t_r[0]};

endmodule

/* hw/rtl/ptpd_queue.sv */
// short queue between front and back, with credit count covering the front latency
// depends on ptpd_pkg
module ptpd_queue #(
  parameter int WIDTH = 201
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             credit_ok,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);
  import ptpd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_r, rd_r;
  logic [CW-1:0]    cnt_r, occ_r;

  // occupancy counts beats in the front pipeline as well as stored ones
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
      occ_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + PW'(1);
      if (pop)  rd_r <= rd_r + PW'(1);
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
      occ_r <= occ_r + CW'(accept) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  assign credit_ok = (occ_r < CW'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

endmodule

/* hw/rtl/ptpd_back.sv */
// back end: pipelined restoring dividers for x, y and z over w, saturation, output register
// depends on ptpd_pkg
module ptpd_back #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int TW          = 50
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [4*TW-1:0]       in_t,
  input  logic                  in_wz,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [3*ptpd_pkg::LANE_W-1:0] out_tdata,
  output logic                  out_tuser
);
  import ptpd_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int QB = W + 1;
  localparam int NW = TW + FRAC_BITS;
  localparam logic [QB-1:0] LIM = QB'(1) << (W - 1);

  logic en;

  logic [TW-1:0] an_a_r [3];
  logic [TW-1:0] ad_a_r;
  logic [2:0]    neg_a_r;
  logic          wz_a_r, va_r;

  logic [TW-1:0] rem_r [3][QB+1];
  logic [TW-1:0] rem_nxt [3][QB+1];
  logic [QB-1:0] low_r [3][QB+1];
  logic [QB-1:0] low_nxt [3][QB+1];
  logic [QB-1:0] quo_r [3][QB+1];
  logic [QB-1:0] quo_nxt [3][QB+1];
  logic [TW-1:0] den_r [QB+1];
  logic [2:0]    neg_r [QB+1];
  logic [2:0]    ovf_r [QB+1];
  logic [2:0]    ovf_nxt;
  logic          wz_r  [QB+1];
  logic          v_r   [QB+1];

  logic [NW-1:0]    num;
  logic [TW+W:0]    hi_ext, den_ext;
  logic [TW:0]      r_sh, diff;
  logic signed [W-1:0] res [3];

  logic                  out_valid_r;
  logic [3*LANE_W-1:0]   out_data_r;
  logic                  out_wz_r;

  assign en  = !out_valid_r || out_tready;
  assign pop = in_valid && en;

  // magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        an_a_r[c]  <= in_t[c*TW + TW-1] ? TW'(-in_t[c*TW +: TW]) : in_t[c*TW +: TW];
        neg_a_r[c] <= in_t[c*TW + TW-1] ^ in_t[3*TW + TW-1];
      end
      ad_a_r <= in_t[4*TW-1] ? TW'(-in_t[3*TW +: TW]) : in_t[3*TW +: TW];
      wz_a_r <= in_wz;
    end
  end

  always_comb begin
    num     = '0;
    hi_ext  = '0;
    den_ext = '0;
    r_sh    = '0;
    diff    = '0;
    ovf_nxt = '0;
    // overflow when the quotient would need more than QB bits
    for (int c = 0; c < 3; c++) begin
      num     = {an_a_r[c], {FRAC_BITS{1'b0}}};
      hi_ext  = (TW+W+1)'(num >> QB);
      den_ext = (TW+W+1)'(ad_a_r);
      ovf_nxt[c]    = (hi_ext >= den_ext);
      rem_nxt[c][0] = hi_ext[TW-1:0];
      low_nxt[c][0] = num[QB-1:0];
      quo_nxt[c][0] = '0;
    end
    // one quotient bit per stage
    for (int k = 0; k < QB; k++) begin
      for (int c = 0; c < 3; c++) begin
        r_sh = {rem_r[c][k], low_r[c][k][QB-1]};
        diff = r_sh - {1'b0, den_r[k]};
        rem_nxt[c][k+1] = diff[TW] ? r_sh[TW-1:0] : diff[TW-1:0];
        low_nxt[c][k+1] = low_r[c][k] << 1;
        quo_nxt[c][k+1] = {quo_r[c][k][QB-2:0], !diff[TW]};
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (neg_r[QB][c]) begin
        if (ovf_r[QB][c] || (quo_r[c][QB] > LIM)) res[c] = LIM[W-1:0];
        else                                       res[c] = W'(~quo_r[c][QB] + QB'(1));
      end else begin
        if (ovf_r[QB][c] || (quo_r[c][QB] >= LIM)) res[c] = W'(LIM - QB'(1));
        else                                        res[c] = quo_r[c][QB][W-1:0];
      end
      if (wz_r[QB]) res[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k <= QB; k++) begin
          rem_r[c][k] <= (k == 0) ? rem_nxt[c][0] : rem_nxt[c][k];
          low_r[c][k] <= low_nxt[c][k];
          quo_r[c][k] <= quo_nxt[c][k];
        end
      end
      den_r[0] <= ad_a_r;
      neg_r[0] <= neg_a_r;
      ovf_r[0] <= ovf_nxt;
      wz_r[0]  <= wz_a_r;
      for (int k = 0; k < QB; k++) begin
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
        wz_r[k+1]  <= wz_r[k];
      end
      out_data_r <= {LANE_W'(res[2]), LANE_W'(res[1]), LANE_W'(res[0])};
      out_wz_r   <= wz_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= QB; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      va_r   <= in_valid;
      v_r[0] <= va_r;
      for (int k = 0; k < QB; k++) v_r[k+1] <= v_r[k];
      out_valid_r <= v_r[QB];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_wz_r;

endmodule

/* hw/rtl/point_transform_perspective_divide.sv */
// top level: homogeneous point transform with perspective divide
// depends on ptpd_pkg, ptpd_front, ptpd_queue, ptpd_back
//
// Accepts one point per clock and returns one transformed point per clock when the
// output is not stalled. A point passes through the multiply and sum front end,
// the four-entry queue, the set-up registers and the bit-per-stage divider
// pipeline of the back end, then the output register.
// in_tready falls only when four points sit between the input and the divider.
// Matrix writes are taken at any time on the cfg channel but belong to idle periods.
module point_transform_perspective_divide #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [3*ptpd_pkg::LANE_W-1:0]      in_tdata,   // in_x, in_y, in_z
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [3*ptpd_pkg::LANE_W-1:0]      out_tdata,  // out_x, out_y, out_z
  output logic                               out_tuser,  // w_zero
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ptpd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ptpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ptpd_pkg::*;

  localparam int PRW = 2*COORD_WIDTH - FRAC_BITS;
  localparam int TW  = ((PRW > COORD_WIDTH) ? PRW : COORD_WIDTH) + 2;
  localparam int QW  = 4*TW + 1;

  cfg_write_t   cfg_wr;
  logic         accept, f_valid, f_wz, q_pop, q_credit, q_ne;
  logic [4*TW-1:0] f_t;
  logic [QW-1:0]   q_head;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = '{valid: cfg_valid, addr: cfg_addr, data: cfg_data};
  assign in_tready = q_credit;
  assign accept    = in_tvalid && q_credit;

  ptpd_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .TW(TW)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_wr(cfg_wr), .in_accept(accept), .in_data(in_tdata),
    .out_valid(f_valid), .out_t(f_t), .out_wz(f_wz)
  );

  ptpd_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst_n(rst_n), .accept(accept), .push(f_valid), .push_data({f_wz, f_t}),
    .pop(q_pop), .credit_ok(q_credit), .not_empty(q_ne), .head(q_head)
  );

  ptpd_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS), .TW(TW)) u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(q_ne), .in_t(q_head[4*TW-1:0]),
    .in_wz(q_head[QW-1]), .pop(q_pop), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule
